[rtl/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// pidc_pkg
// Types, widths and register codes shared by the incremental PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  localparam int DATA_W     = 16;               // target / measured width
  localparam int ERR_W      = DATA_W + 2;       // error history width
  localparam int GAIN_W     = 15;               // register width
  localparam int COEF_W     = GAIN_W + 3;       // signed A/B/C coefficient
  localparam int PROD_W     = ERR_W + COEF_W;
  localparam int INC_W      = PROD_W + 2;       // sum of three products
  localparam int ACC_W      = 48;
  localparam int RAW_W      = ACC_W + 1;
  localparam int BOUND_SCALE = 100;
  localparam int LIM_W      = GAIN_W + 7;       // bound * 100
  localparam int CFG_IDX_W  = 4;

  // set-point filter: divide by 10 through a reciprocal multiply
  localparam int FSUM_W     = DATA_W + 4;
  localparam int FMAG_W     = DATA_W + 3;
  localparam int DIV_S      = FMAG_W + 4;
  localparam int DIV_M_W    = FMAG_W + 2;
  localparam logic [63:0] DIV_M = ((64'd1 << DIV_S) + 64'd9) / 64'd10;

  localparam int Q_DEPTH_DEF = 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP     = 4'd0,
    REG_KI     = 4'd1,
    REG_KD     = 4'd2,
    REG_BOUND  = 4'd3,
    REG_DB     = 4'd4,
    REG_FILT_EN = 4'd5,
    REG_DB_EN  = 4'd6,
    REG_BND_EN = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [GAIN_W-1:0] kp;
    logic        [GAIN_W-1:0] ki;
    logic        [GAIN_W-1:0] kd;
    logic        [GAIN_W-1:0] bound;
    logic        [GAIN_W-1:0] dead_band;
    logic                     filt_en;
    logic                     db_en;
    logic                     bnd_en;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0]  control_out;
    logic signed [ACC_W-1:0]  increment;
    logic                     in_dead_band;
    logic                     clamped;
  } out_item_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic                     apply;
  } q_item_t;

endpackage

`default_nettype wire

[rtl/pidc_front.sv]
// ----------------------------------------------------------------------------
// pidc_front
// Accepts samples, filters the set-point, forms the error and the dead-band
// decision, and pushes the result into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pidc_pkg::in_item_t in_data,
  input  pidc_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               push,
  output pidc_pkg::q_item_t  push_data
);
  import pidc_pkg::*;

  logic signed [DATA_W-1:0]  tgt1_r, tgt1_nxt;
  logic signed [DATA_W-1:0]  tgt2_r, tgt2_nxt;

  logic signed [FSUM_W-1:0]  fsum;
  logic                      fneg;
  logic        [FMAG_W-1:0]  fmag;
  logic [FMAG_W+DIV_M_W-1:0] fprod;
  logic signed [DATA_W-1:0]  fquo;
  logic signed [DATA_W-1:0]  sp;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W:0]     err_x;
  logic signed [ERR_W:0]     db_x;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    fsum  = FSUM_W'(in_data.target) + (FSUM_W'(tgt1_r) <<< 3) + FSUM_W'(tgt2_r);
    fneg  = fsum[FSUM_W-1];
    fmag  = fneg ? FMAG_W'(-fsum) : FMAG_W'(fsum);
    fprod = fmag * DIV_M[DIV_M_W-1:0];
    fquo  = DATA_W'(fprod >> DIV_S);
    // truncation toward zero: divide the magnitude, then restore the sign
    sp    = cfg.filt_en ? (fneg ? -fquo : fquo) : in_data.target;
    err   = ERR_W'(sp) - ERR_W'(in_data.measured);

    err_x = (ERR_W+1)'(err);
    db_x  = signed'({{(ERR_W+1-GAIN_W){1'b0}}, cfg.dead_band});
    push_data.err   = err;
    push_data.apply = !cfg.db_en || (err_x >= db_x) || (err_x <= -db_x);

    tgt1_nxt = push ? sp : tgt1_r;
    tgt2_nxt = push ? tgt1_r : tgt2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt1_r <= '0;
      tgt2_r <= '0;
    end else begin
      tgt1_r <= tgt1_nxt;
      tgt2_r <= tgt2_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/pidc_queue.sv]
// ----------------------------------------------------------------------------
// pidc_queue
// Short FIFO between front and back end. DEPTH must be 2 or more.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_queue #(
  parameter int DEPTH = pidc_pkg::Q_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pidc_pkg::q_item_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output pidc_pkg::q_item_t q_data
);
  import pidc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t            ent_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/pidc_back.sv]
// ----------------------------------------------------------------------------
// pidc_back
// Execution pipeline: products, increment, accumulate with saturation and
// bound clamp, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pidc_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  pidc_pkg::q_item_t   q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pidc_pkg::out_item_t out_data
);
  import pidc_pkg::*;

  // error history, shifted as items leave the queue
  logic signed [ERR_W-1:0]  e1_r, e1_nxt;
  logic signed [ERR_W-1:0]  e2_r, e2_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  // product stage
  logic                     p_valid_r, p_valid_nxt;
  logic signed [PROD_W-1:0] p_pa_r, p_pb_r, p_pc_r;
  logic                     p_apply_r;
  // increment stage
  logic                     s_valid_r, s_valid_nxt;
  logic signed [INC_W-1:0]  s_inc_r;
  logic                     s_apply_r;
  // output register
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     o_free, s_free, p_free, o_load;
  logic        [COEF_W-1:0] coef_a, coef_b, coef_c;
  logic signed [COEF_W-1:0] a_s, b_s, c_s;
  logic signed [ERR_W-1:0]  e0;
  logic signed [PROD_W-1:0] pa, pb, pc;
  logic signed [INC_W-1:0]  inc;
  logic signed [RAW_W-1:0]  raw;
  logic        [LIM_W-1:0]  lim;
  logic signed [ACC_W-1:0]  lim_s, sum1, sum2;
  logic                     clmp;

  assign o_free = !out_valid_r || !out_stall;
  assign s_free = !s_valid_r || o_free;
  assign p_free = !p_valid_r || s_free;
  assign pop    = q_valid && p_free;
  assign o_load = o_free && s_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    coef_a = COEF_W'(cfg.kp) + COEF_W'(cfg.ki) + COEF_W'(cfg.kd);
    coef_b = COEF_W'(cfg.kp) + (COEF_W'(cfg.kd) << 1);
    coef_c = COEF_W'(cfg.kd);
    a_s    = signed'(coef_a);
    b_s    = signed'(coef_b);
    c_s    = signed'(coef_c);
    e0     = q_data.err;
    pa     = a_s * e0;
    pb     = b_s * e1_r;
    pc     = c_s * e2_r;

    inc    = INC_W'(p_pa_r) - INC_W'(p_pb_r) + INC_W'(p_pc_r);

    raw    = RAW_W'(acc_r) + RAW_W'(s_inc_r);
    lim    = LIM_W'(cfg.bound) * LIM_W'(BOUND_SCALE);
    lim_s  = signed'({{(ACC_W-LIM_W){1'b0}}, lim});
    clmp   = 1'b0;
    sum1   = acc_r;
    if (s_apply_r) begin
      if (raw[RAW_W-1] != raw[RAW_W-2]) begin
        sum1 = raw[RAW_W-1] ? ACC_MIN : ACC_MAX;
        clmp = 1'b1;
      end else begin
        sum1 = raw[ACC_W-1:0];
      end
    end
    sum2 = sum1;
    if (cfg.bnd_en) begin
      if (sum1 >= lim_s) begin
        sum2 = lim_s;
        if (sum1 != lim_s) clmp = 1'b1;
      end else if (sum1 <= -lim_s) begin
        sum2 = -lim_s;
        if (sum1 != -lim_s) clmp = 1'b1;
      end
    end

    out_data_nxt.control_out  = sum2;
    out_data_nxt.increment    = ACC_W'(s_inc_r);
    out_data_nxt.in_dead_band = !s_apply_r;
    out_data_nxt.clamped      = clmp;

    e1_nxt        = pop ? e0 : e1_r;
    e2_nxt        = pop ? e1_r : e2_r;
    acc_nxt       = o_load ? sum2 : acc_r;
    p_valid_nxt   = p_free ? q_valid : p_valid_r;
    s_valid_nxt   = s_free ? p_valid_r : s_valid_r;
    out_valid_nxt = o_free ? s_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r        <= '0;
      e2_r        <= '0;
      acc_r       <= '0;
      p_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      e1_r        <= e1_nxt;
      e2_r        <= e2_nxt;
      acc_r       <= acc_nxt;
      p_valid_r   <= p_valid_nxt;
      s_valid_r   <= s_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p_free) begin
      p_pa_r    <= pa;
      p_pb_r    <= pb;
      p_pc_r    <= pc;
      p_apply_r <= q_data.apply;
    end
    if (s_free) begin
      s_inc_r   <= inc;
      s_apply_r <= p_apply_r;
    end
    if (o_load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/incremental_pid_controller_unit.sv]
// Incremental (velocity form) PID controller. One sample (target, measured)
// is accepted per clock while the queue is not full, and one result is
// returned per sample, in order. The front end filters the set-point and
// forms the error and dead-band decision in the cycle of acceptance; a queue
// of QUEUE_DEPTH items feeds a three-stage back end (products, increment,
// accumulate/clamp into the output register). Sustained rate is one item per
// cycle while the output is not stalled; the accumulator is updated as each
// result is loaded into the output register. in_stall rises only when the
// queue is full. Configuration writes are taken every cycle (cfg_ready is
// always high) and must only be made while no item is in flight.
// ----------------------------------------------------------------------------
// incremental_pid_controller_unit
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_controller_unit #(
  parameter int QUEUE_DEPTH = pidc_pkg::Q_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pidc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pidc_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidc_pkg::GAIN_W-1:0]        cfg_wdata
);
  import pidc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     push, q_full, pop, q_valid;
  q_item_t  push_data, q_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_KP:      cfg_nxt.kp        = cfg_wdata;
        REG_KI:      cfg_nxt.ki        = cfg_wdata;
        REG_KD:      cfg_nxt.kd        = cfg_wdata;
        REG_BOUND:   cfg_nxt.bound     = cfg_wdata;
        REG_DB:      cfg_nxt.dead_band = cfg_wdata;
        REG_FILT_EN: cfg_nxt.filt_en   = cfg_wdata[0];
        REG_DB_EN:   cfg_nxt.db_en     = cfg_wdata[0];
        REG_BND_EN:  cfg_nxt.bnd_en    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pidc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pidc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  pidc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // limit seen by the bound check below
  logic signed [ACC_W-1:0] chk_lim;
  assign chk_lim = signed'({{(ACC_W-LIM_W){1'b0}},
                            LIM_W'(LIM_W'(cfg_r.bound) * LIM_W'(BOUND_SCALE))});

  a_bound_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cfg_r.bnd_en |->
      (out_data.control_out <= chk_lim) && (out_data.control_out >= -chk_lim))
    else $error("control_out outside the enabled bound");

  a_db_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !cfg_r.db_en |-> !out_data.in_dead_band)
    else $error("dead band flagged while disabled");

  a_zero_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cfg_r.bnd_en && (cfg_r.bound == '0) |-> (out_data.control_out == '0))
    else $error("zero bound did not force zero output");

endmodule

`default_nettype wire
